// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, ck, rn, p, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (p)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, ck, rn, a, c, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) else $error(msg);

`endif

// ===== src/cv3_pkg.sv =====
package cv3_pkg;

	localparam int CH_W  = 8;
	localparam int PIX_W = 3 * CH_W;

	typedef logic [PIX_W-1:0] pix_t;

	// register indexes on the configuration port
	localparam int REG_IDX_W = 3;
	localparam int REG_DATA_W = 13;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SEL_X_START  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SEL_X_END    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SEL_Y_START  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SEL_Y_END    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_MAX_VALUE    = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_FILTER_MODE  = 3'd7;

	// filter modes
	localparam logic [1:0] MODE_EDGE    = 2'd0;
	localparam logic [1:0] MODE_SHARPEN = 2'd1;
	localparam logic [1:0] MODE_BOX     = 2'd2;
	localparam logic [1:0] MODE_GAUSS   = 2'd3;

	// lane arithmetic widths
	localparam int SUM_W   = CH_W + 4;   // sum of nine, gaussian weighted sum
	localparam int CROSS_W = CH_W + 2;   // sum of four
	localparam int VAL_W   = CH_W + 6;   // signed kernel result

	// floor(x/18) = (x * BOX_RECIP) >> BOX_SHIFT for x below 2^13
	localparam int BOX_NUM_W  = SUM_W + 1;
	localparam int BOX_RCP_W  = 13;
	localparam int BOX_PROD_W = BOX_NUM_W + BOX_RCP_W;
	localparam logic [BOX_RCP_W-1:0] BOX_RECIP = 13'd7282;
	localparam int BOX_SHIFT = 17;

	localparam int ROW_W = 12;
	localparam int COL_W_OUT = 10;

	// output queue
	localparam int QDEPTH = 16;
	localparam int QAW = $clog2(QDEPTH);

	// per-item info that travels beside the lanes
	typedef struct packed {
		logic                 interior;
		logic                 border;
		logic                 sel;
		logic [ROW_W-1:0]     irow;
		logic [COL_W_OUT-1:0] icol;
		logic [ROW_W-1:0]     brow;
		logic [COL_W_OUT-1:0] bcol;
		pix_t                 pix;
		pix_t                 centre;
	} side_t;

	typedef struct packed {
		logic                 last;
		logic [CH_W-1:0]      blue;
		logic [CH_W-1:0]      green;
		logic [CH_W-1:0]      red;
		logic [COL_W_OUT-1:0] col;
		logic [ROW_W-1:0]     row;
	} res_t;

endpackage

// ===== src/cv3_ram.sv =====
module cv3_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/cv3_lane.sv =====
// One color channel of the 3x3 kernel: sums in the first stage,
// kernel select, box division and clamp in the second.
module cv3_lane (
	input  logic                     clk,
	input  logic [1:0]               mode,
	input  logic [cv3_pkg::CH_W-1:0] max_value,
	input  logic [cv3_pkg::CH_W-1:0] v [9],
	output logic [cv3_pkg::CH_W-1:0] res
);

	localparam int CH_W    = cv3_pkg::CH_W;
	localparam int SUM_W   = cv3_pkg::SUM_W;
	localparam int CROSS_W = cv3_pkg::CROSS_W;
	localparam int VAL_W   = cv3_pkg::VAL_W;
	localparam int NUM_W   = cv3_pkg::BOX_NUM_W;
	localparam int PROD_W  = cv3_pkg::BOX_PROD_W;

	logic [SUM_W-1:0]   sum9_c, gsum_c;
	logic [CROSS_W-1:0] cross_c;

	logic [SUM_W-1:0]   sum9_s2, gsum_s2;
	logic [CROSS_W-1:0] cross_s2;
	logic [CH_W-1:0]    ctr_s2;

	logic [NUM_W-1:0]      box_num;
	logic [PROD_W-1:0]     box_prod;
	logic [SUM_W:0]        g_round;
	logic signed [VAL_W-1:0] val;
	logic [CH_W-1:0]       res_s3;

	always_comb begin
		cross_c = CROSS_W'(v[1]) + CROSS_W'(v[3]) + CROSS_W'(v[5]) + CROSS_W'(v[7]);
		sum9_c  = SUM_W'(v[0]) + SUM_W'(v[2]) + SUM_W'(v[6]) + SUM_W'(v[8])
			+ SUM_W'(cross_c) + SUM_W'(v[4]);
		gsum_c  = SUM_W'(v[0]) + SUM_W'(v[2]) + SUM_W'(v[6]) + SUM_W'(v[8])
			+ SUM_W'({cross_c, 1'b0}) + SUM_W'({v[4], 2'b00});
	end

	always_ff @(posedge clk) begin
		sum9_s2  <= sum9_c;
		gsum_s2  <= gsum_c;
		cross_s2 <= cross_c;
		ctr_s2   <= v[4];
	end

	always_comb begin
		box_num  = NUM_W'({sum9_s2, 1'b0}) + NUM_W'(9);
		box_prod = PROD_W'(box_num) * PROD_W'(cv3_pkg::BOX_RECIP);
		g_round  = (SUM_W + 1)'(gsum_s2) + (SUM_W + 1)'(8);
		unique case (mode)
			cv3_pkg::MODE_EDGE: begin
				val = $signed(VAL_W'({ctr_s2, 3'b000}) + VAL_W'(ctr_s2))
					- $signed(VAL_W'(sum9_s2));
			end
			cv3_pkg::MODE_SHARPEN: begin
				val = $signed(VAL_W'({ctr_s2, 2'b00}) + VAL_W'(ctr_s2))
					- $signed(VAL_W'(cross_s2));
			end
			cv3_pkg::MODE_BOX: begin
				val = $signed(VAL_W'(box_prod[PROD_W-1:cv3_pkg::BOX_SHIFT]));
			end
			cv3_pkg::MODE_GAUSS: begin
				val = $signed(VAL_W'(g_round[SUM_W:4]));
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (val < 0) begin
			res_s3 <= '0;
		end else if (val > $signed(VAL_W'(max_value))) begin
			res_s3 <= max_value;
		end else begin
			res_s3 <= val[CH_W-1:0];
		end
	end

	assign res = res_s3;

endmodule

// ===== src/cv3_merge.sv =====
`include "assert_macros.svh"

// Joins lane results with the pass-through data and queues the items.
// Queue space is reserved when a pixel is accepted, so pushes never overflow.
module cv3_merge (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rsv,
	input  logic [1:0]               rsv_n,
	input  logic                     in_valid,
	input  cv3_pkg::side_t           side,
	input  logic [cv3_pkg::CH_W-1:0] lane_res [3],
	output logic                     room,
	output logic                     m_valid,
	input  logic                     m_ready,
	output cv3_pkg::res_t            m_res
);

	localparam int CH_W = cv3_pkg::CH_W;
	localparam int QAW  = cv3_pkg::QAW;
	localparam int CW   = QAW + 1;

	cv3_pkg::res_t queue_q [cv3_pkg::QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [CW-1:0]  cnt_q, used_q;

	cv3_pkg::res_t ires, bres, first;
	logic [1:0] n_push;
	logic       pop;

	always_comb begin
		ires.row   = side.irow;
		ires.col   = side.icol;
		ires.red   = side.sel ? lane_res[0] : side.centre[0*CH_W +: CH_W];
		ires.green = side.sel ? lane_res[1] : side.centre[1*CH_W +: CH_W];
		ires.blue  = side.sel ? lane_res[2] : side.centre[2*CH_W +: CH_W];
		ires.last  = !side.border;

		bres.row   = side.brow;
		bres.col   = side.bcol;
		bres.red   = side.pix[0*CH_W +: CH_W];
		bres.green = side.pix[1*CH_W +: CH_W];
		bres.blue  = side.pix[2*CH_W +: CH_W];
		bres.last  = 1'b1;

		// delayed interior item goes ahead of the border item
		first  = side.interior ? ires : bres;
		n_push = in_valid ? ({1'b0, side.interior} + {1'b0, side.border}) : 2'd0;
	end

	assign m_valid = (cnt_q != '0);
	assign m_res   = queue_q[rd_q];
	assign pop     = m_valid && m_ready;
	assign room    = (used_q <= CW'(cv3_pkg::QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			queue_q[wr_q] <= first;
		end
		if (n_push == 2'd2) begin
			queue_q[wr_q + QAW'(1)] <= bres;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			cnt_q  <= '0;
			used_q <= '0;
		end else begin
			wr_q   <= wr_q + QAW'(n_push);
			rd_q   <= rd_q + QAW'(pop);
			cnt_q  <= cnt_q + CW'(n_push) - CW'(pop);
			used_q <= used_q + (rsv ? CW'(rsv_n) : CW'(0)) - CW'(pop);
		end
	end

	`ASSERT_ALWAYS(a_cnt_within_used, clk, arst_n, cnt_q <= used_q, "queue count above reservation")
	`ASSERT_ALWAYS(a_no_overflow, clk, arst_n, (32'(cnt_q) + 32'(n_push)) <= cv3_pkg::QDEPTH, "queue overflow")

endmodule

// ===== src/conv3x3_rgb_filter_stream.sv =====
// 3x3 convolution over an RGB raster stream, one pixel taken per clock while
// the queue has room. The line buffer is a single RAM of MAX_WIDTH entries
// holding the two rows above; it is read when a pixel is accepted and written
// back in the next cycle through its own write port, so pixels can follow back
// to back. Every result goes through the same pipeline (line buffer and window,
// lane sums, kernel, divide and clamp) and passes the stage 1, lane sum, clamp
// and queue registers, from the accept of the pixel that releases it, before it
// is offered on the output: a border pixel releases itself, an interior pixel
// is released by the pixel one row below and one column right. Each result
// carries its row and column. Results leave through a 16-entry queue at one per
// clock while m_tready is high. Pixels in the last column from the third row on,
// and in the last row from the third column on, yield two results each, so a
// run of them grows the queue by one entry per clock. Each accepted pixel
// reserves queue space for its results at once, and input stalls while fewer
// than two entries are left unreserved. Configure only while idle.
`include "assert_macros.svh"

module conv3x3_rgb_filter_stream #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // out_row, out_col, red_out, green_out, blue_out, zero pad
	output logic        m_tlast,   // last_of_step
	input  logic        cfg_we,
	input  logic [cv3_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [cv3_pkg::REG_DATA_W-1:0] cfg_wdata
);

	localparam int CH_W  = cv3_pkg::CH_W;
	localparam int PIX_W = cv3_pkg::PIX_W;
	localparam int ROW_W = cv3_pkg::ROW_W;
	localparam int OCW   = cv3_pkg::COL_W_OUT;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int XW    = 14;
	localparam logic [10:0] W_LIMIT = (MAX_WIDTH > 2047) ? 11'd2047 : 11'(MAX_WIDTH);
	localparam logic [12:0] H_LIMIT = 13'd4096;

	// configuration
	logic [10:0] image_width_q, sel_x_start_q, sel_x_end_q;
	logic [12:0] image_height_q, sel_y_start_q, sel_y_end_q;
	logic [CH_W-1:0] max_value_q;
	logic [1:0]  filter_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 11'd1024;
			image_height_q <= 13'd4096;
			sel_x_start_q  <= '0;
			sel_x_end_q    <= 11'd1024;
			sel_y_start_q  <= '0;
			sel_y_end_q    <= 13'd4096;
			max_value_q    <= 8'd255;
			filter_mode_q  <= cv3_pkg::MODE_EDGE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cv3_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata[10:0];
				cv3_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_wdata[12:0];
				cv3_pkg::REG_SEL_X_START:  sel_x_start_q  <= cfg_wdata[10:0];
				cv3_pkg::REG_SEL_X_END:    sel_x_end_q    <= cfg_wdata[10:0];
				cv3_pkg::REG_SEL_Y_START:  sel_y_start_q  <= cfg_wdata[12:0];
				cv3_pkg::REG_SEL_Y_END:    sel_y_end_q    <= cfg_wdata[12:0];
				cv3_pkg::REG_MAX_VALUE:    max_value_q    <= cfg_wdata[CH_W-1:0];
				cv3_pkg::REG_FILTER_MODE:  filter_mode_q  <= cfg_wdata[1:0];
			endcase
		end
	end

	// position and classification of the arriving pixel
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             acc, room;
	logic [10:0]      w_eff;
	logic [12:0]      h_eff;
	logic [XW-1:0]    rowx, colx, wx, hx, rx, cx;
	logic             interior, border, sel;
	logic [1:0]       n_acc;

	assign acc      = s_tvalid && s_tready;
	assign s_tready = room;

	always_comb begin
		w_eff = (image_width_q == '0) ? 11'd1
			: ((image_width_q > W_LIMIT) ? W_LIMIT : image_width_q);
		h_eff = (image_height_q == '0) ? 13'd1
			: ((image_height_q > H_LIMIT) ? H_LIMIT : image_height_q);
		rowx = XW'(row_q);
		colx = XW'(col_q);
		wx   = XW'(w_eff);
		hx   = XW'(h_eff);
		rx   = rowx - XW'(1);
		cx   = colx - XW'(1);
		interior = (rowx >= XW'(2)) && (colx >= XW'(2))
			&& (rowx <= hx - XW'(1)) && (colx <= wx - XW'(1));
		border = (rowx == '0) || (colx == '0)
			|| (rowx >= hx - XW'(1)) || (colx >= wx - XW'(1));
		sel = (rx >= XW'(sel_y_start_q)) && (rx < XW'(sel_y_end_q))
			&& (cx >= XW'(sel_x_start_q)) && (cx < XW'(sel_x_end_q));
		n_acc = {1'b0, interior} + {1'b0, border};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (acc) begin
			if (colx + XW'(1) >= wx) begin
				col_q <= '0;
				row_q <= (rowx + XW'(1) >= hx) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// stage 1: line buffer read returns, window shifts, buffer written back
	logic             valid_s1, valid_s2, valid_s3;
	logic [COL_W-1:0] addr_s1;
	cv3_pkg::side_t   side_s1, side_c, side_s2, side_s3;
	logic [2*PIX_W-1:0] lb_rdata;
	cv3_pkg::pix_t    top, mid;
	cv3_pkg::pix_t    win0_q [3];
	cv3_pkg::pix_t    win1_q [3];
	cv3_pkg::pix_t    col2 [3];

	always_ff @(posedge clk) begin
		if (acc) begin
			addr_s1          <= col_q;
			side_s1.interior <= interior;
			side_s1.border   <= border;
			side_s1.sel      <= sel;
			side_s1.irow     <= row_q - ROW_W'(1);
			side_s1.icol     <= cx[OCW-1:0];
			side_s1.brow     <= row_q;
			side_s1.bcol     <= colx[OCW-1:0];
			side_s1.pix      <= s_tdata[PIX_W-1:0];
			side_s1.centre   <= '0;
		end
	end

	// entry holds {older row, newer row}
	cv3_ram #(
		.WIDTH (2 * PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (addr_s1),
		.wdata ({mid, side_s1.pix}),
		.re    (acc),
		.raddr (col_q),
		.rdata (lb_rdata)
	);

	assign top = lb_rdata[2*PIX_W-1:PIX_W];
	assign mid = lb_rdata[PIX_W-1:0];

	always_comb begin
		col2[0] = top;
		col2[1] = mid;
		col2[2] = side_s1.pix;
		side_c = side_s1;
		side_c.centre = win1_q[1];
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			win0_q <= win1_q;
			win1_q <= col2;
		end
		side_s2 <= side_c;
		side_s3 <= side_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// channel lanes
	logic [CH_W-1:0] lv [3][9];
	logic [CH_W-1:0] lres [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int r = 0; r < 3; r++) begin
				lv[k][r*3 + 0] = win0_q[r][k*CH_W +: CH_W];
				lv[k][r*3 + 1] = win1_q[r][k*CH_W +: CH_W];
				lv[k][r*3 + 2] = col2[r][k*CH_W +: CH_W];
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_lane
		cv3_lane u_lane (
			.clk       (clk),
			.mode      (filter_mode_q),
			.max_value (max_value_q),
			.v         (lv[k]),
			.res       (lres[k])
		);
	end

	cv3_pkg::res_t m_res;

	cv3_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.rsv      (acc),
		.rsv_n    (n_acc),
		.in_valid (valid_s3),
		.side     (side_s3),
		.lane_res (lres),
		.room     (room),
		.m_valid  (m_tvalid),
		.m_ready  (m_tready),
		.m_res    (m_res)
	);

	assign m_tdata = {2'b00, m_res.blue, m_res.green, m_res.red, m_res.col, m_res.row};
	assign m_tlast = m_res.last;

	`ASSERT_NEXT(a_s1_follows_accept, clk, arst_n, acc, valid_s1, "accepted pixel missing in stage 1")

endmodule

// ===== tb/sv/conv3x3_tb_pkg.sv =====
package conv3x3_tb_pkg;

	import cv3_pkg::*;

	// Mirrors the filter: line buffers, window and position, plus the queue of
	// results still owed by the block.
	class conv3x3_scoreboard;
		logic [10:0] width_reg;
		logic [12:0] height_reg;
		logic [10:0] sel_x_lo, sel_x_hi;
		logic [12:0] sel_y_lo, sel_y_hi;
		logic [7:0]  clamp_max;
		logic [1:0]  mode;

		pix_t older_line [1024];
		pix_t newer_line [1024];
		pix_t win_cols [2][3];   // [column][row], column 1 is nearer
		int unsigned row_pos, col_pos;
		int nbh [3][3];          // one lane of the window, [row][col]

		res_t expected_q [$];
		int errors;

		function new();
			width_reg = 11'd1024;
			height_reg = 13'd4096;
			sel_x_lo = '0;
			sel_x_hi = 11'd1024;
			sel_y_lo = '0;
			sel_y_hi = 13'd4096;
			clamp_max = 8'd255;
			mode = MODE_EDGE;
			foreach (older_line[i]) begin
				older_line[i] = '0;
				newer_line[i] = '0;
			end
			foreach (win_cols[c, r]) win_cols[c][r] = '0;
			row_pos = 0;
			col_pos = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] v);
			case (idx)
				REG_IMAGE_WIDTH:  width_reg = v[10:0];
				REG_IMAGE_HEIGHT: height_reg = v[12:0];
				REG_SEL_X_START:  sel_x_lo = v[10:0];
				REG_SEL_X_END:    sel_x_hi = v[10:0];
				REG_SEL_Y_START:  sel_y_lo = v[12:0];
				REG_SEL_Y_END:    sel_y_hi = v[12:0];
				REG_MAX_VALUE:    clamp_max = v[7:0];
				REG_FILTER_MODE:  mode = v[1:0];
				default: ;
			endcase
		endfunction

		function bit at_origin();
			return row_pos == 0 && col_pos == 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function logic [7:0] filter_lane();
			int s, sum9, hi;
			hi = clamp_max;
			sum9 = 0;
			foreach (nbh[r, c]) sum9 += nbh[r][c];
			case (mode)
				MODE_EDGE:    s = 9 * nbh[1][1] - sum9;
				MODE_SHARPEN: s = 5 * nbh[1][1] - nbh[0][1] - nbh[1][0] - nbh[1][2] - nbh[2][1];
				MODE_BOX:     s = (2 * sum9 + 9) / 18;
				default: begin
					s = nbh[0][0] + 2 * nbh[0][1] + nbh[0][2]
						+ 2 * nbh[1][0] + 4 * nbh[1][1] + 2 * nbh[1][2]
						+ nbh[2][0] + 2 * nbh[2][1] + nbh[2][2];
					s = (s + 8) / 16;
				end
			endcase
			if (s < 0) s = 0;
			if (s > hi) s = hi;
			return s[7:0];
		endfunction

		// One accepted pixel: work out the results it releases, then advance.
		function void note_pixel(pix_t p);
			int unsigned w, h, row, col;
			pix_t top, mid;
			res_t step_res [$];
			res_t r;
			logic [7:0] lane [3];
			bit sel;
			w = width_reg;
			h = height_reg;
			if (w < 1) w = 1;
			if (w > 1024) w = 1024;
			if (h < 1) h = 1;
			if (h > 4096) h = 4096;
			row = row_pos;
			col = col_pos;
			if (col >= 1024) col = 1023;
			top = older_line[col];
			mid = newer_line[col];

			// centre of the window is one row up, one column left
			if (row >= 2 && col >= 2 && row <= h - 1 && col <= w - 1) begin
				sel = (row - 1) >= sel_y_lo && (row - 1) < sel_y_hi
					&& (col - 1) >= sel_x_lo && (col - 1) < sel_x_hi;
				for (int k = 0; k < 3; k++) begin
					if (sel) begin
						for (int c = 0; c < 2; c++)
							for (int rr = 0; rr < 3; rr++)
								nbh[rr][c] = win_cols[c][rr][8*k +: 8];
						nbh[0][2] = top[8*k +: 8];
						nbh[1][2] = mid[8*k +: 8];
						nbh[2][2] = p[8*k +: 8];
						lane[k] = filter_lane();
					end else begin
						lane[k] = win_cols[1][1][8*k +: 8];
					end
				end
				r.row = 12'(row - 1);
				r.col = 10'(col - 1);
				r.red = lane[0];
				r.green = lane[1];
				r.blue = lane[2];
				r.last = 1'b0;
				step_res.push_back(r);
			end

			if (row == 0 || col == 0 || row >= h - 1 || col >= w - 1) begin
				r.row = 12'(row);
				r.col = 10'(col);
				r.red = p[7:0];
				r.green = p[15:8];
				r.blue = p[23:16];
				r.last = 1'b0;
				step_res.push_back(r);
			end

			if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
			foreach (step_res[i]) expected_q.push_back(step_res[i]);

			win_cols[0] = win_cols[1];
			win_cols[1][0] = top;
			win_cols[1][1] = mid;
			win_cols[1][2] = p;
			older_line[col] = mid;
			newer_line[col] = p;

			if (col + 1 >= w) begin
				col_pos = 0;
				row_pos = (row + 1 >= h) ? 0 : row + 1;
			end else begin
				col_pos = col + 1;
			end
		endfunction

		function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
			if (exp_v != got_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				$error("result row %0d col %0d with none pending", got.row, got.col);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("out_row", want.row, got.row);
			compare_field("out_col", want.col, got.col);
			compare_field("red_out", want.red, got.red);
			compare_field("green_out", want.green, got.green);
			compare_field("blue_out", want.blue, got.blue);
			compare_field("last_of_step", want.last, got.last);
		endfunction
	endclass

endpackage

// ===== tb/sv/tb_conv3x3_rgb_filter_stream.sv =====
module tb_conv3x3_rgb_filter_stream;

	timeunit 1ns;
	timeprecision 1ps;

	import cv3_pkg::*;
	import conv3x3_tb_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 400;
	localparam int unsigned DRAIN_CYCLES = 32;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	pix_t s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [REG_DATA_W-1:0] cfg_wdata = '0;

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned cycle_count = 0;
	logic [REG_DATA_W-1:0] cfg_vals [8];
	conv3x3_scoreboard sb;

	conv3x3_rgb_filter_stream u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(res_t'({m_tlast, m_tdata[45:0]}));
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic set_idling(input int unsigned phase);
		case (phase % 4)
			0: begin idle_pct = 0; stall_pct = 0; end
			1: begin idle_pct = 67; stall_pct = 0; end
			2: begin idle_pct = 0; stall_pct = 67; end
			default: begin idle_pct = 7; stall_pct = 7; end
		endcase
	endtask

	// one register per clock, all eight in index order
	task automatic program_registers();
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_IDX_W'(i);
			cfg_wdata <= cfg_vals[i];
			sb.set_reg(REG_IDX_W'(i), cfg_vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic pick_span(input int unsigned extent, input int unsigned full_end,
			input int unsigned reg_bits, output logic [REG_DATA_W-1:0] lo,
			output logic [REG_DATA_W-1:0] hi);
		int unsigned a;
		case ($urandom_range(9))
			0, 1: begin lo = '0; hi = REG_DATA_W'(full_end); end
			2: begin
				// empty or inverted
				a = $urandom_range(extent);
				lo = REG_DATA_W'(a);
				hi = REG_DATA_W'($urandom_range(a));
			end
			3: begin
				lo = REG_DATA_W'($urandom_range((1 << reg_bits) - 1));
				hi = REG_DATA_W'($urandom_range((1 << reg_bits) - 1));
			end
			default: begin
				a = $urandom_range(extent - 1);
				lo = REG_DATA_W'(a);
				hi = REG_DATA_W'($urandom_range(extent, a + 1));
			end
		endcase
	endtask

	task automatic pick_config(input int unsigned w, input int unsigned h);
		int unsigned ew, eh;
		ew = (w == 0) ? 1 : ((w > 1024) ? 1024 : w);
		eh = (h == 0) ? 1 : ((h > 4096) ? 4096 : h);
		cfg_vals[REG_IMAGE_WIDTH] = REG_DATA_W'(w);
		cfg_vals[REG_IMAGE_HEIGHT] = REG_DATA_W'(h);
		pick_span(ew, 1024, 11, cfg_vals[REG_SEL_X_START], cfg_vals[REG_SEL_X_END]);
		pick_span(eh, 4096, 13, cfg_vals[REG_SEL_Y_START], cfg_vals[REG_SEL_Y_END]);
		case ($urandom_range(7))
			0: cfg_vals[REG_MAX_VALUE] = '0;
			1, 2: cfg_vals[REG_MAX_VALUE] = REG_DATA_W'(255);
			default: cfg_vals[REG_MAX_VALUE] = REG_DATA_W'($urandom_range(255));
		endcase
		cfg_vals[REG_FILTER_MODE] = REG_DATA_W'($urandom_range(3));
	endtask

	function automatic pix_t random_pixel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	task automatic send_pixel(input pix_t p);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= p;
		do @(posedge clk); while (!s_tready);
		sb.note_pixel(p);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Feeds random pixels until the position wraps back to the first pixel.
	// Optionally stops partway to pick a new height, selection, clamp and mode
	// (width kept, so no stale line entry is ever read).
	task automatic run_image(input bit allow_resize, output int unsigned sent);
		int unsigned resize_at;
		sent = 0;
		resize_at = 0;
		if (allow_resize && $urandom_range(4) == 0) resize_at = $urandom_range(24, 1);
		do begin
			send_pixel(random_pixel());
			sent++;
			if (sent == resize_at && !sb.at_origin()) begin
				wait_idle();
				pick_config(cfg_vals[REG_IMAGE_WIDTH], $urandom_range(10));
				program_registers();
			end
		end while (!sb.at_origin());
		wait_idle();
	endtask

	initial begin
		logic [1:0] modes [4];
		logic [7:0] centre_v, around_v, red_v;
		int unsigned sent, random_items, img, w, h;
		sb = new();
		modes = '{MODE_EDGE, MODE_SHARPEN, MODE_BOX, MODE_GAUSS};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// one 3x3 image per kernel; the edge and sharpen images drive the clamps at both ends
		for (int m = 0; m < 4; m++) begin
			set_idling(m);
			cfg_vals[REG_IMAGE_WIDTH] = REG_DATA_W'(3);
			cfg_vals[REG_IMAGE_HEIGHT] = REG_DATA_W'(3);
			cfg_vals[REG_SEL_X_START] = '0;
			cfg_vals[REG_SEL_X_END] = REG_DATA_W'(1024);
			cfg_vals[REG_SEL_Y_START] = '0;
			cfg_vals[REG_SEL_Y_END] = REG_DATA_W'(4096);
			cfg_vals[REG_MAX_VALUE] = REG_DATA_W'(255);
			cfg_vals[REG_FILTER_MODE] = REG_DATA_W'(modes[m]);
			program_registers();
			case (modes[m])
				MODE_EDGE:    begin centre_v = 8'hff; around_v = 8'h00; end
				MODE_SHARPEN: begin centre_v = 8'h00; around_v = 8'hff; end
				MODE_BOX:     begin centre_v = 8'hff; around_v = 8'hff; end
				default:      begin centre_v = 8'hff; around_v = 8'h00; end
			endcase
			for (int i = 0; i < 9; i++) begin
				red_v = (i == 4) ? centre_v : around_v;
				send_pixel({8'($urandom), ~red_v, red_v});
			end
			wait_idle();
		end

		// size extreme: width over range, one full row
		set_idling(2);
		pick_config(2047, 1);
		program_registers();
		run_image(1'b0, sent);

		random_items = 0;
		img = 0;
		while (random_items < RANDOM_ITEMS) begin
			set_idling(img);
			case ($urandom_range(19))
				0: w = 0;
				1: w = 1;
				2: w = 2;
				3: w = $urandom_range(40, 11);
				default: w = $urandom_range(10, 3);
			endcase
			case ($urandom_range(19))
				0: h = 0;
				1: h = 1;
				2: h = 2;
				default: h = $urandom_range(8, 3);
			endcase
			pick_config(w, h);
			program_registers();
			run_image(1'b1, sent);
			random_items += sent;
			img++;
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
